// ----- hdl/psdmx_pkg.sv -----
// Shared types, codes and helpers for the program stream private payload demux.
package psdmx_pkg;

  // Input beat: one byte of the program stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // Result beat: one payload byte and/or an end report.
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  substream_id;
    logic        pts_valid;
    logic [32:0] pts;
    logic        end_of_unit;
    logic [2:0]  status;
    logic [15:0] drop_count;
  } out_beat_t;

  // End status codes.
  typedef enum logic [2:0] {
    ST_INPUT_END   = 3'd0,
    ST_SYSTEM_END  = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_BAD_HDR_LEN = 3'd3,
    ST_UNKNOWN     = 3'd4,
    ST_MPEG1_TS    = 3'd5,
    ST_TRUNCATED   = 3'd6
  } status_t;

  // Parser phases.
  typedef enum logic [4:0] {
    PH_SEARCH     = 5'd0,
    PH_PACKMODE   = 5'd1,
    PH_SKIP       = 5'd2,
    PH_SKLEN_HI   = 5'd3,
    PH_SKLEN_LO   = 5'd4,
    PH_PVLEN_HI   = 5'd5,
    PH_PVLEN_LO   = 5'd6,
    PH_PRIV_FIRST = 5'd7,
    PH_PRIV_STD   = 5'd8,
    PH_PRIV_C2    = 5'd9,
    PH_FLAGS      = 5'd10,
    PH_HDRLEN     = 5'd11,
    PH_PTS0       = 5'd12,
    PH_PTS1       = 5'd13,
    PH_PTS2       = 5'd14,
    PH_PTS3       = 5'd15,
    PH_PTS4       = 5'd16,
    PH_HDRSKIP    = 5'd17,
    PH_AID        = 5'd18,
    PH_PAYLOAD    = 5'd19
  } phase_t;

  // Stream ids and field masks.
  localparam logic [7:0] SID_END     = 8'hb9;
  localparam logic [7:0] SID_PACK    = 8'hba;
  localparam logic [7:0] SID_PRIV1   = 8'hbd;
  localparam logic [7:0] SID_PADDING = 8'hbe;
  localparam logic [7:0] SID_AV_LO   = 8'hc0;
  localparam logic [7:0] SID_AV_HI   = 8'hf0;
  localparam logic [7:0] PACK_MPEG1_LEN = 8'd7;
  localparam logic [7:0] PACK_MPEG2_LEN = 8'd9;
  localparam logic [7:0] PTS_LEN        = 8'd5;

  // Five raw PTS bytes to the 33-bit value; zero when a marker fails.
  function automatic logic [32:0] decode_pts(input logic [39:0] raw);
    logic [7:0] b0, b1, b2, b3, b4;
    b0 = raw[39:32];
    b1 = raw[31:24];
    b2 = raw[23:16];
    b3 = raw[15:8];
    b4 = raw[7:0];
    if (b0[7:4] == 4'h2 && b0[0] && b2[0] && b4[0]) begin
      decode_pts = {b0[3:1], b1, b2[7:1], b3, b4[7:1]};
    end else begin
      decode_pts = '0;
    end
  endfunction

endpackage

// ----- hdl/psdmx_parser.sv -----
// Front end: start code search, header parsing and result classification.
module psdmx_parser
  import psdmx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      beat_valid,
  input  in_beat_t  beat,
  output logic      res_valid,
  output out_beat_t res
);

  phase_t      phase_r, phase_nxt;
  logic [23:0] win_r, win_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [16:0] brem_r, brem_nxt;
  logic [7:0]  hrem_r, hrem_nxt;
  logic [39:0] pts_r, pts_nxt;
  logic        flag_r, flag_nxt;
  logic [7:0]  sub_r, sub_nxt;
  logic [15:0] emit_r, emit_nxt;
  logic        disc_r, disc_nxt;

  logic        end_v, pay;
  status_t     st;
  logic [7:0]  b;
  logic [16:0] br1, need;
  logic [15:0] emit_cnt;

  assign b    = beat.data_byte;
  assign br1  = brem_r + 17'd1;
  assign need = br1 + {9'd0, b} + 17'd1;

  // Next-state logic for one byte
  always_comb begin
    phase_nxt = phase_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    plen_nxt  = plen_r;
    brem_nxt  = brem_r;
    hrem_nxt  = hrem_r;
    pts_nxt   = pts_r;
    flag_nxt  = flag_r;
    sub_nxt   = sub_r;
    emit_nxt  = emit_r;
    disc_nxt  = disc_r;
    end_v     = 1'b0;
    pay       = 1'b0;
    st        = ST_INPUT_END;
    if (!disc_r) begin
      case (phase_r)
        PH_SEARCH: begin
          if (fill_r == 2'd3 && win_r == 24'd1) begin
            if (b == SID_END) begin
              end_v = 1'b1; st = ST_SYSTEM_END;
            end else if (b == SID_PACK) begin
              phase_nxt = PH_PACKMODE;
            end else if (b == SID_PRIV1) begin
              phase_nxt = PH_PVLEN_HI; flag_nxt = 1'b0; pts_nxt = '0;
            end else if (b == SID_PADDING || (b >= SID_AV_LO && b < SID_AV_HI)) begin
              phase_nxt = PH_SKLEN_HI;
            end else begin
              end_v = 1'b1; st = ST_UNKNOWN;
            end
          end else begin
            win_nxt = {win_r[15:0], b};
            if (fill_r != 2'd3) fill_nxt = fill_r + 2'd1;
          end
        end
        PH_PACKMODE: begin
          if (b[7:6] == 2'b01) begin
            brem_nxt = {9'd0, PACK_MPEG2_LEN}; phase_nxt = PH_SKIP;
          end else if (b[7:4] == 4'h2) begin
            brem_nxt = {9'd0, PACK_MPEG1_LEN}; phase_nxt = PH_SKIP;
          end else begin
            end_v = 1'b1; st = ST_BAD_VERSION;
          end
        end
        PH_SKIP: begin
          brem_nxt = brem_r - 17'd1;
          if (brem_nxt == '0) begin
            phase_nxt = PH_SEARCH; win_nxt = '0; fill_nxt = '0;
          end
        end
        PH_SKLEN_HI, PH_PVLEN_HI: begin
          plen_nxt  = {b, 8'd0};
          phase_nxt = (phase_r == PH_SKLEN_HI) ? PH_SKLEN_LO : PH_PVLEN_LO;
        end
        PH_SKLEN_LO: begin
          plen_nxt = {plen_r[15:8], b};
          brem_nxt = {1'b0, plen_r[15:8], b};
          if (plen_nxt == '0) begin
            phase_nxt = PH_SEARCH; win_nxt = '0; fill_nxt = '0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_PVLEN_LO: begin
          plen_nxt  = {plen_r[15:8], b};
          phase_nxt = PH_PRIV_FIRST;
        end
        PH_PRIV_FIRST, PH_PRIV_STD, PH_PRIV_C2: begin
          if (phase_r == PH_PRIV_FIRST) brem_nxt = 17'd1;
          else if (phase_r == PH_PRIV_STD) brem_nxt = 17'd2;
          else brem_nxt = 17'd3;
          if (phase_r == PH_PRIV_STD) begin
            phase_nxt = PH_PRIV_C2;
          end else if (phase_r == PH_PRIV_FIRST && b[7:6] == 2'b01) begin
            phase_nxt = PH_PRIV_STD;
          end else if (b[7:4] == 4'h2 || b[7:4] == 4'h3) begin
            end_v = 1'b1; st = ST_MPEG1_TS;
          end else if (b[7:6] == 2'b10) begin
            phase_nxt = PH_FLAGS;
          end else begin
            phase_nxt = PH_SEARCH; win_nxt = '0; fill_nxt = '0;
          end
        end
        PH_FLAGS: begin
          brem_nxt  = br1;
          flag_nxt  = (b[7:6] == 2'b10);
          phase_nxt = PH_HDRLEN;
        end
        PH_HDRLEN: begin
          brem_nxt = br1;
          if (need > {1'b0, plen_r} || (flag_r && b < PTS_LEN)) begin
            end_v = 1'b1; st = ST_BAD_HDR_LEN;
          end else begin
            brem_nxt = {1'b0, plen_r} - need;
            if (flag_r) begin
              hrem_nxt = b - PTS_LEN; phase_nxt = PH_PTS0;
            end else begin
              hrem_nxt  = b;
              phase_nxt = (b != 8'd0) ? PH_HDRSKIP : PH_AID;
            end
          end
        end
        PH_PTS0, PH_PTS1, PH_PTS2, PH_PTS3: begin
          pts_nxt   = {pts_r[31:0], b};
          phase_nxt = phase_t'(phase_r + 5'd1);
        end
        PH_PTS4: begin
          pts_nxt   = {7'd0, decode_pts({pts_r[31:0], b})};
          phase_nxt = (hrem_r != 8'd0) ? PH_HDRSKIP : PH_AID;
        end
        PH_HDRSKIP: begin
          hrem_nxt = hrem_r - 8'd1;
          if (hrem_nxt == 8'd0) phase_nxt = PH_AID;
        end
        PH_AID: begin
          sub_nxt  = b;
          emit_nxt = '0;
          if (brem_r == '0) begin
            phase_nxt = PH_SEARCH; win_nxt = '0; fill_nxt = '0;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (beat.last_byte && brem_r > 17'd1) begin
            end_v = 1'b1; st = ST_TRUNCATED;
          end else begin
            pay      = 1'b1;
            emit_nxt = emit_r + 16'd1;
            brem_nxt = brem_r - 17'd1;
            if (brem_nxt == '0) begin
              phase_nxt = PH_SEARCH; win_nxt = '0; fill_nxt = '0;
            end
          end
        end
        default: begin
          phase_nxt = PH_SEARCH; win_nxt = '0; fill_nxt = '0;
        end
      endcase
      // buffer end with no other end reason
      if (!end_v && beat.last_byte) begin
        end_v = 1'b1;
        st    = (phase_nxt == PH_PAYLOAD) ? ST_TRUNCATED : ST_INPUT_END;
      end
      if (end_v && !beat.last_byte) disc_nxt = 1'b1;
    end
    // count of this packet's bytes, taken before the end clears it
    emit_cnt = emit_nxt;
    // every last byte returns to reset state
    if (beat.last_byte && (end_v || disc_r)) begin
      phase_nxt = PH_SEARCH;
      win_nxt   = '0;
      fill_nxt  = '0;
      plen_nxt  = '0;
      brem_nxt  = '0;
      hrem_nxt  = '0;
      pts_nxt   = '0;
      flag_nxt  = 1'b0;
      sub_nxt   = '0;
      emit_nxt  = '0;
      disc_nxt  = 1'b0;
    end
  end

  // Result beat from the classified byte
  always_comb begin
    res_valid         = beat_valid && !disc_r && (pay || end_v);
    res.payload_valid = pay;
    res.payload_byte  = pay ? b : 8'd0;
    res.substream_id  = pay ? sub_r : 8'd0;
    res.pts_valid     = pay && flag_r;
    res.pts           = (pay && flag_r) ? pts_r[32:0] : 33'd0;
    res.end_of_unit   = end_v;
    res.status        = end_v ? st : ST_INPUT_END;
    res.drop_count    = (end_v && st == ST_TRUNCATED) ? emit_cnt : 16'd0;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      win_r   <= '0;
      fill_r  <= '0;
      plen_r  <= '0;
      brem_r  <= '0;
      hrem_r  <= '0;
      pts_r   <= '0;
      flag_r  <= 1'b0;
      sub_r   <= '0;
      emit_r  <= '0;
      disc_r  <= 1'b0;
    end else if (beat_valid) begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      plen_r  <= plen_nxt;
      brem_r  <= brem_nxt;
      hrem_r  <= hrem_nxt;
      pts_r   <= pts_nxt;
      flag_r  <= flag_nxt;
      sub_r   <= sub_nxt;
      emit_r  <= emit_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

// ----- hdl/psdmx_fifo.sv -----
// Back end: short result queue between the parser and the output port.
module psdmx_fifo
  import psdmx_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_beat_t wr_data,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output out_beat_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  out_beat_t        mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rp_r];

  // Pointer and count update with wrap
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    if (do_pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_data;
  end

endmodule

// ----- hdl/program_stream_private_payload_demux_top.sv -----
// Top level of the program stream private stream 1 payload demux.
// Takes one stream byte per clock, unless the result queue is full, on a push/full port
// and returns payload bytes and end reports on an empty/pop port. The parser decides
// each byte in the cycle it is accepted; each result is registered in a queue of
// RESULT_DEPTH beats that decouples the parser from the consumer: push stalls only
// when that queue is full. Every byte marked last_byte returns the parser to reset state.
module program_stream_private_payload_demux_top
  import psdmx_pkg::*;
#(
  parameter int RESULT_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_beat_t  in_data,
  output logic      in_full,
  input  logic      out_pop,
  output logic      out_empty,
  output out_beat_t out_data
);

  logic      res_valid;
  out_beat_t res;

  psdmx_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (in_push && !in_full),
    .beat       (in_data),
    .res_valid  (res_valid),
    .res        (res)
  );

  psdmx_fifo #(.DEPTH(RESULT_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_valid),
    .wr_data (res),
    .full    (in_full),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // Queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // Drop count only on a truncated end
  a_drop_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.drop_count != 16'd0) |->
      (out_data.end_of_unit && out_data.status == ST_TRUNCATED))
    else $error("drop count without truncated end");

  // PTS fields only with a payload byte
  a_pts_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.payload_valid) |->
      (!out_data.pts_valid && out_data.pts == 33'd0))
    else $error("pts reported without payload");

  // Every result carries a payload byte or an end
  a_nonempty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.payload_valid || out_data.end_of_unit))
    else $error("empty result beat");
`endif

endmodule
